// ----- rtl/core/cfir_pkg.sv -----
// cfir_pkg: shared types and constants of the crossfading FIR filter.
// Used by the controller, the datapath and the top level.
package cfir_pkg;

    localparam logic [1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [1:0] CMD_COEF_WR  = 2'd1;
    localparam logic [1:0] CMD_ACTIVATE = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam int ONE_Q16   = 65536;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int ACC_W     = 56;
    localparam int KOUT_W    = 40;

    localparam logic [0:0] REG_TAPER_LENGTH = 1'b0;
    localparam logic [0:0] REG_TAPER_STEP   = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic hist_wr;       // write new sample into history ring
        logic coef_wr;       // write coefficient to idle bank
        logic mac_clear;     // clear accumulator
        logic mac_en;        // accumulate product of read data
        logic mac_bank;      // unused; the read bank comes from coef_bank
        logic save_old;      // latch rounded accumulator as old-kernel output
        logic save_new;      // latch rounded accumulator as new-kernel output
        logic blend_mul;     // form the two gain products
        logic blend_sum;     // add, shift and saturate into the output register
    } cfir_cmd_t;

endpackage

// ----- rtl/core/cfir_ram.sv -----
// cfir_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module cfir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/cfir_ctrl.sv -----
// cfir_ctrl: controller of the crossfading FIR filter; sequences the MAC walk,
// the taper gain and the output handshake. Depends on cfir_pkg.
module cfir_ctrl #(
    parameter int NUM_TAPS = 64,
    parameter int GAIN_TABLE_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_cmd,
    input  logic [5:0]                  in_tap,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_taper,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_idx,
    input  logic [16:0]                 cfg_data,
    output cfir_pkg::cfir_cmd_t         cmd,
    output logic [$clog2(NUM_TAPS)-1:0] tap_addr,
    output logic [$clog2(NUM_TAPS)-1:0] hist_base,
    output logic                        coef_bank,
    output logic                        active_bank,
    output logic [GAIN_TABLE_BITS:0]    gain_idx
);

    localparam int TW = $clog2(NUM_TAPS);
    localparam int CW = $clog2(NUM_TAPS + 1);
    localparam int PHASE_SHIFT = 16 - GAIN_TABLE_BITS;
    localparam int ONE_Q16_C = cfir_pkg::ONE_Q16;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [1:0]    pipe_reg, pipe_next;     // read latency stages in flight
    logic          pass_reg, pass_next;     // 0 old kernel, 1 new kernel
    logic [CW-1:0] fill_reg, fill_next;
    logic [TW-1:0] wptr_reg, wptr_next;
    logic          bank_reg, bank_next;
    logic          taper_reg, taper_next;
    logic [16:0]   tcount_reg, tcount_next;
    logic [15:0]   tlen_reg;
    logic [16:0]   tstep_reg;
    logic          blend_reg, blend_next;
    logic [16:0]   phase_reg, phase_next;
    logic [33:0]   prod;

    assign prod = tcount_reg * tstep_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg  <= '0;
            tstep_reg <= 17'(ONE_Q16_C);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                cfir_pkg::REG_TAPER_LENGTH: tlen_reg  <= cfg_data[15:0];
                cfir_pkg::REG_TAPER_STEP:   tstep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pipe_reg   <= '0;
            pass_reg   <= 1'b0;
            fill_reg   <= '0;
            wptr_reg   <= '0;
            bank_reg   <= 1'b0;
            taper_reg  <= 1'b0;
            tcount_reg <= '0;
            blend_reg  <= 1'b0;
            phase_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pipe_reg   <= pipe_next;
            pass_reg   <= pass_next;
            fill_reg   <= fill_next;
            wptr_reg   <= wptr_next;
            bank_reg   <= bank_next;
            taper_reg  <= taper_next;
            tcount_reg <= tcount_next;
            blend_reg  <= blend_next;
            phase_reg  <= phase_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign out_taper   = blend_reg;
    assign tap_addr    = cnt_reg;
    assign hist_base   = wptr_reg;
    assign active_bank = bank_reg;
    assign coef_bank   = pass_reg ? bank_reg : (blend_reg ? ~bank_reg : bank_reg);
    assign gain_idx    = phase_reg[16:PHASE_SHIFT];

    // Sequence one item
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pipe_next   = {pipe_reg[0], 1'b0};
        pass_next   = pass_reg;
        fill_next   = fill_reg;
        wptr_next   = wptr_reg;
        bank_next   = bank_reg;
        taper_next  = taper_reg;
        tcount_next = tcount_reg;
        blend_next  = blend_reg;
        phase_next  = phase_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        cfir_pkg::CMD_COEF_WR:
                        begin
                            cmd.coef_wr = (32'(in_tap) < NUM_TAPS);
                        end
                        cfir_pkg::CMD_ACTIVATE:
                        begin
                            bank_next   = ~bank_reg;
                            taper_next  = 1'b1;
                            tcount_next = '0;
                        end
                        cfir_pkg::CMD_CLEAR:
                        begin
                            fill_next   = '0;
                            taper_next  = 1'b0;
                            tcount_next = '0;
                        end
                        default:
                        begin
                            cmd.hist_wr = 1'b1;
                            wptr_next   = (32'(wptr_reg) == NUM_TAPS - 1) ? '0 : wptr_reg + 1'b1;
                            if (32'(fill_reg) < NUM_TAPS)
                                fill_next = fill_reg + 1'b1;
                            if (32'(fill_reg) >= NUM_TAPS - 1)
                            begin
                                blend_next = taper_reg;
                                if ((tcount_reg == {1'b0, tlen_reg}) || (prod > 34'(ONE_Q16_C)))
                                    phase_next = 17'(ONE_Q16_C);
                                else
                                    phase_next = prod[16:0];
                                if (taper_reg)
                                begin
                                    if (tcount_reg >= {1'b0, tlen_reg})
                                    begin
                                        taper_next  = 1'b0;
                                        tcount_next = '0;
                                    end
                                    else
                                        tcount_next = tcount_reg + 1'b1;
                                end
                                pass_next     = ~taper_reg;
                                cnt_next      = '0;
                                cmd.mac_clear = 1'b1;
                                state_next    = S_MAC;
                            end
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                pipe_next[0] = 1'b1;
                cmd.mac_en   = pipe_reg[1];
                if (32'(cnt_reg) == NUM_TAPS - 1)
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DRAIN:
            begin
                cmd.mac_en = pipe_reg[1];
                if (pipe_reg == 2'b00)
                begin
                    cnt_next = '0;
                    if (pass_reg)
                    begin
                        cmd.save_new = 1'b1;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        cmd.save_old  = 1'b1;
                        cmd.mac_clear = 1'b1;
                        pass_next     = 1'b1;
                        state_next    = S_MAC;
                    end
                end
            end
            S_MUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                cmd.blend_sum = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output stays put while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> (state_reg == S_OUT))
        else $error("result dropped while stalled");
    // No item accepted while a result is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    // Fill never exceeds the tap count
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= NUM_TAPS)
        else $error("history fill overflow");

endmodule

// ----- rtl/core/cfir_dp.sv -----
// cfir_dp: datapath of the crossfading FIR filter: history and coefficient RAMs,
// the shared MAC, the gain ROM and the blend. Depends on cfir_pkg and cfir_ram.
module cfir_dp #(
    parameter int NUM_TAPS = 64,
    parameter int GAIN_TABLE_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfir_pkg::cfir_cmd_t         cmd,
    input  logic [$clog2(NUM_TAPS)-1:0] tap_addr,
    input  logic [$clog2(NUM_TAPS)-1:0] hist_base,
    input  logic                        coef_bank,
    input  logic                        active_bank,
    input  logic [GAIN_TABLE_BITS:0]    gain_idx,
    input  logic                        blend,
    input  logic signed [23:0]          sample_in,
    input  logic [5:0]                  tap_index,
    input  logic signed [17:0]          coef_value,
    output logic signed [23:0]          sample_out,
    output logic                        saturated
);

    localparam int TW = $clog2(NUM_TAPS);
    localparam int ROM_SIZE = (1 << GAIN_TABLE_BITS) + 1;
    localparam logic [17:0] ONE_Q16_S = 18'(cfir_pkg::ONE_Q16);

    // sin^2 ROM entries: Q30 sine series, squared, rounded to Q16
    function automatic logic [16:0] sin_sq(input int i);
        longint unsigned x, x2, term, s, sq;
        longint sum;
        x = (64'd1686629713 * 64'(i) + (64'd1 << (GAIN_TABLE_BITS - 1))) >> GAIN_TABLE_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        s = 64'(sum);
        if (s > (64'd1 << 30))
            s = 64'd1 << 30;
        sq = (s * s) >> 30;
        sq = (sq + (64'd1 << 13)) >> 14;
        if (sq > 64'd65536)
            sq = 64'd65536;
        return 17'(sq);
    endfunction

    logic [16:0] gain_rom [ROM_SIZE];
    for (genvar g = 0; g < ROM_SIZE; g++)
    begin : g_rom
        assign gain_rom[g] = sin_sq(g);
    end

    // History ring: oldest sample sits at the write pointer
    logic [TW-1:0] h_raddr, h_waddr;
    logic [TW:0]   h_sum;
    logic signed [23:0] h_rdata;
    assign h_sum   = {1'b0, hist_base} + {1'b0, tap_addr};
    assign h_raddr = (32'(h_sum) >= NUM_TAPS) ? TW'(32'(h_sum) - NUM_TAPS) : h_sum[TW-1:0];
    assign h_waddr = hist_base;

    cfir_ram #(.WIDTH(24), .DEPTH(NUM_TAPS)) u_hist (
        .clk(clk), .we(cmd.hist_wr), .waddr(h_waddr), .wdata(sample_in),
        .raddr(h_raddr), .rdata(h_rdata));

    // Coefficient banks with per-entry valid bits (reset reads as zero)
    logic [TW:0] c_waddr, c_raddr;
    logic [17:0] c_rdata;
    logic [2*NUM_TAPS-1:0] cvalid_reg;
    logic cv_q_reg;
    assign c_waddr = {~active_bank, tap_index[TW-1:0]};
    assign c_raddr = {coef_bank, tap_addr};

    cfir_ram #(.WIDTH(18), .DEPTH(2*NUM_TAPS)) u_coef (
        .clk(clk), .we(cmd.coef_wr), .waddr(c_waddr), .wdata(coef_value),
        .raddr(c_raddr), .rdata(c_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
            cv_q_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.coef_wr)
                cvalid_reg[c_waddr] <= 1'b1;
            cv_q_reg <= cvalid_reg[c_raddr];
        end
    end

    // Product stage then accumulate
    logic signed [41:0] prod_reg;
    logic signed [55:0] acc_reg;
    logic signed [39:0] old_reg, new_reg, kround;
    logic signed [55:0] acc_rnd;
    logic signed [17:0] coef_eff;
    assign coef_eff = cv_q_reg ? signed'(c_rdata) : '0;
    assign acc_rnd  = acc_reg + 56'sd65536;
    assign kround   = 40'(acc_rnd >>> 17);

    logic signed [58:0] p_old_reg, p_new_reg;
    logic [16:0] g_new;
    logic signed [59:0] bsum;
    logic signed [43:0] y;
    assign g_new = gain_rom[gain_idx];
    assign bsum  = 60'(p_old_reg) + 60'(p_new_reg) + 60'sd32768;
    assign y     = 44'(bsum >>> 16);

    always_ff @(posedge clk)
    begin
        prod_reg <= h_rdata * coef_eff;
        if (cmd.mac_clear)
            acc_reg <= '0;
        else if (cmd.mac_en)
            acc_reg <= acc_reg + 56'(prod_reg);
        if (cmd.save_old)
            old_reg <= kround;
        if (cmd.save_new)
            new_reg <= kround;
        if (cmd.blend_mul)
        begin
            if (blend)
            begin
                p_old_reg <= signed'({1'b0, 18'(ONE_Q16_S - {1'b0, g_new})}) * old_reg;
                p_new_reg <= signed'({1'b0, g_new}) * new_reg;
            end
            else
            begin
                p_old_reg <= '0;
                p_new_reg <= 59'(new_reg) <<< 16;
            end
        end
        if (cmd.blend_sum)
        begin
            if (y > 44'sd8388607)
            begin
                sample_out <= 24'sd8388607;
                saturated  <= 1'b1;
            end
            else if (y < -44'sd8388608)
            begin
                sample_out <= -24'sd8388608;
                saturated  <= 1'b1;
            end
            else
            begin
                sample_out <= y[23:0];
                saturated  <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/crossfading_fir_filter_unit.sv -----
// crossfading_fir_filter_unit: top level of the crossfading FIR filter.
// Depends on cfir_pkg, cfir_ctrl, cfir_dp and cfir_ram.
//
//  channel | direction | payload
//  s_axis  | in        | tdata: cmd, sample_in, tap_index, coef_value
//  m_axis  | out       | tdata: sample_out; tuser: in_taper, saturated
//  cfg     | in        | cfg_we, cfg_index, cfg_data
//
// A sample with a full history makes the single MAC walk the active kernel
// once, or the old and then the new kernel during a crossfade, before its
// result is offered; other commands are handled in the idle state.
// Reset clears control state and the coefficient valid bits. A stalled
// result holds the block until taken.
module crossfading_fir_filter_unit #(
    parameter int NUM_TAPS = 64,
    parameter int GAIN_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // cmd[1:0], sample_in[25:2], tap_index[31:26], coef_value[49:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample_out[23:0]
    output logic [1:0]  m_axis_tuser,   // in_taper[0], saturated[1]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int TW = $clog2(NUM_TAPS);

    cfir_pkg::cfir_cmd_t cmd;
    logic [TW-1:0] tap_addr, hist_base;
    logic coef_bank, taper, sat;
    logic [GAIN_TABLE_BITS:0] gain_idx;
    logic active_bank;
    logic signed [23:0] y;

    cfir_ctrl #(.NUM_TAPS(NUM_TAPS), .GAIN_TABLE_BITS(GAIN_TABLE_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tdata[1:0]), .in_tap(s_axis_tdata[31:26]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_taper(taper),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .tap_addr(tap_addr), .hist_base(hist_base),
        .coef_bank(coef_bank), .active_bank(active_bank), .gain_idx(gain_idx));

    cfir_dp #(.NUM_TAPS(NUM_TAPS), .GAIN_TABLE_BITS(GAIN_TABLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .tap_addr(tap_addr), .hist_base(hist_base),
        .coef_bank(coef_bank), .active_bank(active_bank), .gain_idx(gain_idx),
        .blend(taper), .sample_in(s_axis_tdata[25:2]), .tap_index(s_axis_tdata[31:26]),
        .coef_value(s_axis_tdata[49:32]), .sample_out(y), .saturated(sat));

    assign m_axis_tdata = y;
    assign m_axis_tuser = {sat, taper};

endmodule
